[hdl/dsp_pkg.sv]
// Shared constants, codes and types of the DAC sample player.
package dsp_pkg;

	// Sample store and stepping limits
	localparam int SAMPLE_DEPTH = 65536;
	localparam int MAX_STEP     = 16;
	localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);

	// Field and register widths
	localparam int KIND_W  = 3;
	localparam int SADDR_W = 16;
	localparam int SVAL_W  = 8;
	localparam int DAC_W   = 8;
	localparam int POS_W   = 17;
	localparam int PHASE_W = 21;
	localparam int FRAC_W  = 16;
	localparam int RATE_W  = 20;
	localparam int VOL_W   = 11;
	localparam int CFG_W   = 20;
	localparam int CIDX_W  = 3;

	// Running sum of up to MAX_STEP samples and its count
	localparam int SUM_W = $clog2(MAX_STEP * 255 + 1);
	localparam int CNT_W = $clog2(MAX_STEP + 1);

	// Reset values and fixed levels
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
	localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(256);
	localparam logic [DAC_W-1:0]  SILENCE    = DAC_W'(128);

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STOP    = 3'd4;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_START_ADDR = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_END_ADDR   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_LOOP_EN    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_RATE_INC   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_VOLUME     = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_DAC_EN     = 3'd5;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_resp_t;

endpackage

[hdl/dsp_divider.sv]
// Restoring divider, one quotient bit per cycle, for the sample average.
module dsp_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  dsp_pkg::div_req_t   req,
	output dsp_pkg::div_resp_t  resp
);

	localparam int STEP_W = $clog2(dsp_pkg::SUM_W + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [dsp_pkg::CNT_W-1:0]  rem_q;
	logic [dsp_pkg::SUM_W-1:0]  quo_q;
	logic [dsp_pkg::CNT_W-1:0]  divisor_q;
	logic [dsp_pkg::CNT_W:0]    shifted;
	logic [dsp_pkg::CNT_W+1:0]  trial;

	// Shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[dsp_pkg::SUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};

	// Iterate over the dividend bits, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(dsp_pkg::SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[dsp_pkg::CNT_W+1]) begin
				rem_q <= trial[dsp_pkg::CNT_W-1:0];
				quo_q <= {quo_q[dsp_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[dsp_pkg::CNT_W-1:0];
				quo_q <= {quo_q[dsp_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	assign resp.done     = done_q;
	assign resp.quotient = quo_q;

endmodule

[hdl/dac_sample_player.sv]
// Top level of the DAC sample player: store, phase stepping, averaging and scaling.
// A tick that consumes N samples alternates ST_READ and ST_ACC per sample, runs the SUM_W (12)
// bit divider in ST_DIV, applies the volume, clamps in ST_SCALE and loads the output in ST_EMIT.
// Other items are handled in ST_IDLE; an idle tick stays there and a silent tick loads SILENCE
// through ST_EMIT. Items are taken one at a time: s_axis_tready is high only in ST_IDLE.
// Reset: arst_n clears control state and restores register reset values; the sample
// store is not cleared and holds undefined data until written.
module dac_sample_player (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // [15:0] sample_address, [23:16] sample_value
	input  logic [dsp_pkg::KIND_W-1:0]    s_axis_tuser,  // [2:0] kind
	// Output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dsp_pkg::DAC_W-1:0]     m_axis_tdata,  // [7:0] dac_value
	// Configuration writes
	input  logic                          cfg_we,
	input  logic [dsp_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [dsp_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_DIV,
		ST_SCALE,
		ST_EMIT
	} state_t;

	localparam int PROD_W = dsp_pkg::DAC_W + dsp_pkg::VOL_W + 3;

	// Configuration registers
	logic [dsp_pkg::SADDR_W-1:0] start_q;
	logic [dsp_pkg::POS_W-1:0]   end_q;
	logic                        loop_q;
	logic [dsp_pkg::RATE_W-1:0]  rate_q;
	logic [dsp_pkg::VOL_W-1:0]   volume_q;
	logic                        dac_en_q;

	// Playback state
	state_t                      state_q;
	logic [dsp_pkg::POS_W-1:0]   pos_q;
	logic [dsp_pkg::PHASE_W-1:0] phase_q;
	logic                        playing_q;
	logic                        released_q;
	logic                        muted_q;
	logic [dsp_pkg::SUM_W-1:0]   sum_q;
	logic [dsp_pkg::CNT_W-1:0]   count_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic [dsp_pkg::DAC_W-1:0]   result_q;
	logic                        m_valid_q;
	logic [dsp_pkg::DAC_W-1:0]   m_data_q;

	// Sample store
	logic [dsp_pkg::SVAL_W-1:0]  store [dsp_pkg::SAMPLE_DEPTH];
	logic [dsp_pkg::SVAL_W-1:0]  rdata_q;
	logic                        mem_we;
	logic                        mem_re;

	// Item fields
	logic                        in_txn;
	logic [dsp_pkg::SADDR_W-1:0] in_addr;
	logic [dsp_pkg::SVAL_W-1:0]  in_value;

	// Tick decisions
	logic [dsp_pkg::PHASE_W:0]   phase_sum;
	logic [dsp_pkg::PHASE_W-1:0] phase_sat;
	logic                        phase_due;
	logic [dsp_pkg::POS_W-1:0]   pos_eff;
	logic                        more;
	logic [dsp_pkg::SUM_W-1:0]   sum_next;
	logic                        out_free;

	// Scaling
	logic signed [dsp_pkg::DAC_W+1:0] centred;
	logic signed [PROD_W-1:0]         rounded;
	logic signed [PROD_W-1:0]         level;
	logic [dsp_pkg::DAC_W-1:0]        clamped;

	dsp_pkg::div_req_t  div_req;
	dsp_pkg::div_resp_t div_resp;

	assign in_txn   = s_axis_tvalid && s_axis_tready;
	assign in_addr  = s_axis_tdata[dsp_pkg::SADDR_W-1:0];
	assign in_value = s_axis_tdata[dsp_pkg::SADDR_W +: dsp_pkg::SVAL_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Advance the phase by the rate increment, saturating at the top
	assign phase_sum = {1'b0, phase_q} + {2'b00, rate_q};
	assign phase_sat = phase_sum[dsp_pkg::PHASE_W] ? '1 : phase_sum[dsp_pkg::PHASE_W-1:0];
	assign phase_due = |phase_sat[dsp_pkg::PHASE_W-1:dsp_pkg::FRAC_W];

	// Wrap to the loop start when the end is reached and looping is still on
	assign pos_eff = (!released_q && loop_q && (pos_q >= end_q))
		? {1'b0, start_q} : pos_q;

	// Keep consuming while a whole sample is due, within the end and the step limit
	assign sum_next = sum_q + dsp_pkg::SUM_W'(rdata_q);
	assign more     = (|phase_q[dsp_pkg::PHASE_W-1:dsp_pkg::FRAC_W]) && (pos_q < end_q)
		&& (count_q < dsp_pkg::CNT_W'(dsp_pkg::MAX_STEP));

	// Start the average once the last sample has been summed
	assign div_req.start    = (state_q == ST_ACC) && !more;
	assign div_req.dividend = sum_next;
	assign div_req.divisor  = count_q;

	dsp_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// Centre the average and round the scaled value toward zero
	assign centred = $signed({2'b00, div_resp.quotient[dsp_pkg::DAC_W-1:0]})
		- $signed((dsp_pkg::DAC_W+2)'(128));
	assign rounded = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
	assign level   = (rounded >>> 8) + PROD_W'(128);
	always_comb begin
		if (level[PROD_W-1]) begin
			clamped = '0;
		end else if (level > PROD_W'(255)) begin
			clamped = '1;
		end else begin
			clamped = level[dsp_pkg::DAC_W-1:0];
		end
	end

	// Store port
	assign mem_we = in_txn && (s_axis_tuser == dsp_pkg::KIND_LOAD);
	assign mem_re = (state_q == ST_READ);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[dsp_pkg::ADDR_W'(in_addr)] <= in_value;
		end
		if (mem_re) begin
			rdata_q <= store[dsp_pkg::ADDR_W'(pos_q)];
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= '0;
			loop_q   <= 1'b0;
			rate_q   <= dsp_pkg::RATE_RESET;
			volume_q <= dsp_pkg::VOL_RESET;
			dac_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				dsp_pkg::CFG_START_ADDR: start_q  <= cfg_data[dsp_pkg::SADDR_W-1:0];
				dsp_pkg::CFG_END_ADDR:   end_q    <= cfg_data[dsp_pkg::POS_W-1:0];
				dsp_pkg::CFG_LOOP_EN:    loop_q   <= cfg_data[0];
				dsp_pkg::CFG_RATE_INC:   rate_q   <= cfg_data[dsp_pkg::RATE_W-1:0];
				dsp_pkg::CFG_VOLUME:     volume_q <= cfg_data[dsp_pkg::VOL_W-1:0];
				dsp_pkg::CFG_DAC_EN:     dac_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequence items, the read loop, scaling and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			phase_q    <= '0;
			playing_q  <= 1'b0;
			released_q <= 1'b0;
			muted_q    <= 1'b0;
			sum_q      <= '0;
			count_q    <= '0;
			prod_q     <= '0;
			result_q   <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
		end else begin
			// Drop the output once the transaction completes, unless a new result follows
			if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_txn) begin
						case (s_axis_tuser)
							dsp_pkg::KIND_TICK: begin
								if (dac_en_q) begin
									if (!playing_q) begin
										if (!muted_q) begin
											muted_q  <= 1'b1;
											result_q <= dsp_pkg::SILENCE;
											state_q  <= ST_EMIT;
										end
									end else if (!phase_due) begin
										phase_q <= phase_sat;
									end else if (pos_eff >= end_q) begin
										pos_q      <= pos_eff;
										phase_q    <= '0;
										playing_q  <= 1'b0;
										released_q <= 1'b0;
										result_q   <= dsp_pkg::SILENCE;
										state_q    <= ST_EMIT;
									end else begin
										pos_q   <= pos_eff;
										phase_q <= phase_sat;
										sum_q   <= '0;
										count_q <= '0;
										state_q <= ST_READ;
									end
								end
							end
							dsp_pkg::KIND_START: begin
								playing_q  <= 1'b1;
								pos_q      <= {1'b0, start_q};
								phase_q    <= '0;
								released_q <= 1'b0;
							end
							dsp_pkg::KIND_RELEASE: released_q <= 1'b1;
							dsp_pkg::KIND_STOP:    playing_q  <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_READ: begin
					// Consume one sample: the store read is issued at this edge
					phase_q <= phase_q - dsp_pkg::PHASE_W'(1 << dsp_pkg::FRAC_W);
					pos_q   <= pos_q + dsp_pkg::POS_W'(1);
					count_q <= count_q + dsp_pkg::CNT_W'(1);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= sum_next;
					state_q <= more ? ST_READ : ST_DIV;
				end
				ST_DIV: begin
					if (div_resp.done) begin
						prod_q  <= PROD_W'(centred) * PROD_W'($signed({1'b0, volume_q}));
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					result_q <= clamped;
					muted_q  <= 1'b0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= result_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The step limit bounds the samples consumed per tick
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dsp_pkg::CNT_W'(dsp_pkg::MAX_STEP))
		else $error("sample count exceeds the step limit");

	// The average is only ready while the player waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_resp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A finished result is never loaded over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && m_valid_q && !m_axis_tready) |=>
		(state_q == ST_EMIT && $stable(m_data_q)))
		else $error("result loaded while the output was stalled");

	// Store reads and writes never share a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("store written during a read");

endmodule
